### rtl/core/length_prefixed_message_deframer_unit_macros.svh
// assertion macros for the length-prefixed message deframer
`ifndef LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH
`define LENGTH_PREFIXED_MESSAGE_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define LPMD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("lpmd assertion failed");

// next-cycle implication, disabled during reset
`define LPMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("lpmd assertion failed");

`endif

### rtl/core/lpmd_pkg.sv
// shared types and constants for the length-prefixed message deframer
`timescale 1ns / 1ps
`default_nettype none

package lpmd_pkg;

	localparam int unsigned BYTE_W    = 8;
	localparam int unsigned TYPE_W    = 32;
	localparam int unsigned LEN_W     = 32;
	localparam int unsigned MAX_LEN_W = 21;
	// a valid length never exceeds the 21-bit maximum, so 24 bits hold it
	localparam int unsigned LEN_KEEP_W = 24;

	localparam logic [MAX_LEN_W-1:0] MAX_LEN_RESET = MAX_LEN_W'(1024);
	localparam logic [LEN_W-1:0]     MIN_LEN       = LEN_W'(4);

	typedef enum logic [1:0] {
		PH_LEN,
		PH_TYPE,
		PH_DATA,
		PH_SKIP
	} lpmd_phase_t;

	typedef struct packed {
		logic               length_error;
		logic               empty_message;
		logic               last_byte;
		logic [TYPE_W-1:0]  message_type;
		logic [BYTE_W-1:0]  payload_byte;
	} lpmd_result_t;

endpackage

`default_nettype wire

### rtl/core/lpmd_parser.sv
// framing state machine: header assembly, payload counting and skip of bad messages
`timescale 1ns / 1ps
`default_nettype none

module lpmd_parser (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              fire,
	input  wire logic [lpmd_pkg::BYTE_W-1:0]       in_byte,
	input  wire logic [lpmd_pkg::MAX_LEN_W-1:0]    max_len,
	output logic                                   res_valid,
	output lpmd_pkg::lpmd_result_t                 res
);

	lpmd_pkg::lpmd_phase_t phase_q, phase_d;
	logic [1:0]                           hdr_cnt_q, hdr_cnt_d;
	logic [lpmd_pkg::LEN_KEEP_W-1:0]      len_q, len_d;
	logic [lpmd_pkg::TYPE_W-1:0]          type_q, type_d;
	logic [lpmd_pkg::LEN_W-1:0]           rem_q, rem_d;

	logic [lpmd_pkg::LEN_W-1:0]           len_full;
	logic [lpmd_pkg::TYPE_W-1:0]          type_full;
	logic                                 rem_last;

	assign len_full  = {len_q, in_byte};
	assign type_full = {type_q[lpmd_pkg::TYPE_W-lpmd_pkg::BYTE_W-1:0], in_byte};
	assign rem_last  = (rem_q[lpmd_pkg::LEN_W-1:1] == '0);

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		type_d    = type_q;
		rem_d     = rem_q;
		res_valid = 1'b0;
		res       = '0;
		unique case (phase_q)
			lpmd_pkg::PH_LEN: begin
				if (hdr_cnt_q != 2'd3) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
					len_d     = {len_q[lpmd_pkg::LEN_KEEP_W-lpmd_pkg::BYTE_W-1:0], in_byte};
				end else begin
					hdr_cnt_d = 2'd0;
					if (len_full < lpmd_pkg::MIN_LEN ||
					    len_full > lpmd_pkg::LEN_W'(max_len)) begin
						// bad length: flag it and skip the stated byte count
						rem_d            = len_full;
						phase_d          = (len_full == '0) ? lpmd_pkg::PH_LEN
						                                    : lpmd_pkg::PH_SKIP;
						res_valid        = 1'b1;
						res.last_byte    = 1'b1;
						res.length_error = 1'b1;
					end else begin
						len_d   = len_full[lpmd_pkg::LEN_KEEP_W-1:0];
						phase_d = lpmd_pkg::PH_TYPE;
					end
				end
			end
			lpmd_pkg::PH_TYPE: begin
				type_d = type_full;
				if (hdr_cnt_q != 2'd3) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
				end else begin
					hdr_cnt_d = 2'd0;
					if (lpmd_pkg::LEN_W'(len_q) == lpmd_pkg::MIN_LEN) begin
						phase_d           = lpmd_pkg::PH_LEN;
						res_valid         = 1'b1;
						res.message_type  = type_full;
						res.last_byte     = 1'b1;
						res.empty_message = 1'b1;
					end else begin
						rem_d   = lpmd_pkg::LEN_W'(len_q) - lpmd_pkg::MIN_LEN;
						phase_d = lpmd_pkg::PH_DATA;
					end
				end
			end
			lpmd_pkg::PH_DATA: begin
				res_valid        = 1'b1;
				res.payload_byte = in_byte;
				res.message_type = type_q;
				res.last_byte    = rem_last;
				if (rem_last) begin
					rem_d   = '0;
					phase_d = lpmd_pkg::PH_LEN;
				end else begin
					rem_d = rem_q - lpmd_pkg::LEN_W'(1);
				end
			end
			lpmd_pkg::PH_SKIP: begin
				if (rem_last) begin
					rem_d   = '0;
					phase_d = lpmd_pkg::PH_LEN;
				end else begin
					rem_d = rem_q - lpmd_pkg::LEN_W'(1);
				end
			end
			default: begin
				phase_d = lpmd_pkg::PH_LEN;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= lpmd_pkg::PH_LEN;
			hdr_cnt_q <= 2'd0;
			rem_q     <= '0;
		end else if (fire) begin
			phase_q   <= phase_d;
			hdr_cnt_q <= hdr_cnt_d;
			rem_q     <= rem_d;
		end
	end

	// header words are fully rebuilt by shifting before use
	always_ff @(posedge clk) begin
		if (fire) begin
			len_q  <= len_d;
			type_q <= type_d;
		end
	end

endmodule

`default_nettype wire

### rtl/core/lpmd_out_stage.sv
// result register toward the downstream stream
`timescale 1ns / 1ps
`default_nettype none

module lpmd_out_stage (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   load,
	input  wire lpmd_pkg::lpmd_result_t res,
	input  wire logic                   ready,
	output logic                        valid,
	output lpmd_pkg::lpmd_result_t      data
);

	logic                   valid_q;
	lpmd_pkg::lpmd_result_t data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (!valid_q || ready) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_q || ready) && load) begin
			data_q <= res;
		end
	end

	assign valid = valid_q;
	assign data  = data_q;

endmodule

`default_nettype wire

### rtl/core/length_prefixed_message_deframer_unit.sv
// top level of the length-prefixed message deframer
//
//   port group   dir  what moves
//   s_*          in   one stream byte per transaction
//   m_*          out  one payload byte, empty-message or error mark per transaction
//   cfg_*        in   largest accepted length, written with cfg_wen
//
// one byte per cycle sustained while m_tready stays high; input transaction to result valid
// passes the input register, then the framing state update feeding the result register
// arst_n low: back to reading a length word, max length 1024, no results pending
// a stalled m side holds the result register; the input register then holds and
// s_tready drops, so one byte waits inside while a result waits outside
`timescale 1ns / 1ps
`default_nettype none

`include "length_prefixed_message_deframer_unit_macros.svh"

module length_prefixed_message_deframer_unit (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               s_tvalid,
	output logic                                    s_tready,
	input  wire logic [7:0]                         s_tdata,    // in_byte
	output logic                                    m_tvalid,
	input  wire logic                               m_tready,
	output logic [39:0]                             m_tdata,    // payload_byte, message_type
	output logic                                    m_tlast,    // last_byte
	output logic [1:0]                              m_tuser,    // empty_message, length_error
	input  wire logic                               cfg_wen,
	input  wire logic [lpmd_pkg::MAX_LEN_W-1:0]     cfg_wdata   // max_message_length
);

	logic                              byte_vld_s1;
	logic [lpmd_pkg::BYTE_W-1:0]       byte_s1;
	logic [lpmd_pkg::MAX_LEN_W-1:0]    max_len_q;
	logic                              advance;
	logic                              res_valid;
	lpmd_pkg::lpmd_result_t            res;
	lpmd_pkg::lpmd_result_t            out_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= lpmd_pkg::MAX_LEN_RESET;
		end else if (cfg_wen) begin
			max_len_q <= cfg_wdata;
		end
	end

	// byte moves on when the result register is free or being drained
	assign advance  = byte_vld_s1 && (!m_tvalid || m_tready);
	assign s_tready = !byte_vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_vld_s1 <= 1'b0;
		end else if (s_tready) begin
			byte_vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	lpmd_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (advance),
		.in_byte   (byte_s1),
		.max_len   (max_len_q),
		.res_valid (res_valid),
		.res       (res)
	);

	lpmd_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (advance && res_valid),
		.res    (res),
		.ready  (m_tready),
		.valid  (m_tvalid),
		.data   (out_data)
	);

	assign m_tdata = {out_data.message_type, out_data.payload_byte};
	assign m_tlast = out_data.last_byte;
	assign m_tuser = {out_data.length_error, out_data.empty_message};

	`LPMD_ASSERT_IMPL(a_err_result_clean, clk, arst_n, m_tvalid && m_tuser[1], m_tlast && (m_tdata == '0) && !m_tuser[0])
	`LPMD_ASSERT_IMPL(a_empty_result_last, clk, arst_n, m_tvalid && m_tuser[0], m_tlast && (m_tdata[7:0] == '0))
	`LPMD_ASSERT_NEXT(a_s1_holds_on_stall, clk, arst_n, byte_vld_s1 && !advance, byte_vld_s1 && $stable(byte_s1))

endmodule

`default_nettype wire
